/* rtl/awa_pkg.sv */
package awa_pkg;

  localparam int unsigned AngleFracBits   = 13;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned TableLen        = 24;

  localparam int unsigned InW  = 16;
  localparam int unsigned OutW = 15;
  localparam int unsigned LenW = 16;
  localparam int unsigned KW   = 32;
  localparam int unsigned RotW = 34;
  localparam int unsigned VecW = 50;

  localparam int unsigned Sh = 30 - AngleFracBits;

  localparam logic signed [RotW-1:0] PiHalfQ30 = 34'sd1686629713;
  localparam logic signed [RotW-1:0] InvGainQ30 = 34'sd652032874;
  localparam logic signed [RotW-1:0] DeadbandQ30 = 34'sd1073742;
  localparam logic signed [RotW-1:0] RoundHalf = RotW'(64'sd1 <<< (Sh - 1));
  localparam int LimInt = (1686629713 + (1 << (Sh - 1))) >>> Sh;
  localparam logic signed [OutW-1:0] Lim = OutW'(LimInt);

  // k = 0.5 in Q16.16 for equal track and wheel base
  localparam logic [KW-1:0] KReset = 32'd32768;
  localparam logic [LenW-1:0] LenReset = 16'd256;

  // register indexes
  localparam logic CfgTrack = 1'b0;
  localparam logic CfgBase  = 1'b1;

  localparam logic signed [RotW-1:0] AtanTab [TableLen] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [RotW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [RotW-1:0] z;
    logic                   spec;
    logic                   spec_nz;
  } vec_t;

  typedef struct packed {
    logic start;
    logic busy;
  } kdiv_ctl_t;

  // round Q30 to the output format and clamp to +-pi/2
  function automatic logic signed [OutW-1:0] fold_out(input logic signed [RotW-1:0] z);
    logic signed [RotW-1:0] r;
    logic signed [RotW-1:0] lim_w;
    logic signed [OutW-1:0] res;
    r = (z + RoundHalf) >>> Sh;
    lim_w = RotW'(Lim);
    if (r > lim_w) begin
      res = Lim;
    end else if (r < -lim_w) begin
      res = -Lim;
    end else begin
      res = r[OutW-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/awa_kdiv.sv */
module awa_kdiv import awa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LenW-1:0] track_i,
  input  logic [LenW-1:0] base_i,
  input  kdiv_ctl_t       ctl_i,
  output logic            busy_o,
  output logic [KW-1:0]   k_o
);

  logic [LenW-1:0] base_eff;
  logic [KW-1:0]   num_q, quo_q, k_q;
  logic [LenW:0]   den_q, rem_q, rem_d;
  logic [LenW+1:0] trial;
  logic            qbit, busy_q;
  logic [4:0]      cnt_q;

  assign base_eff = (base_i == '0) ? LenW'(1) : base_i;

  always_comb begin
    trial = {rem_q, num_q[KW-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? (LenW+1)'(trial - {1'b0, den_q}) : trial[LenW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      k_q    <= KReset;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        k_q    <= {quo_q[KW-2:0], qbit};
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q <= {track_i, 16'b0} + {16'b0, base_eff};
      den_q <= {base_eff, 1'b0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[KW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[KW-2:0], qbit};
    end
  end

  assign busy_o = busy_q || ctl_i.busy;
  assign k_o    = k_q;

endmodule

/* rtl/awa_rot_cell.sv */
module awa_rot_cell import awa_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  rot_t a_i,
  output rot_t a_o
);

  rot_t d, q;
  logic signed [RotW-1:0] dx, dy;

  always_comb begin
    dx = a_i.y >>> Idx;
    dy = a_i.x >>> Idx;
    if (a_i.z >= 0) begin
      d.x = a_i.x - dx;
      d.y = a_i.y + dy;
      d.z = a_i.z - AtanTab[Idx];
    end else begin
      d.x = a_i.x + dx;
      d.y = a_i.y - dy;
      d.z = a_i.z + AtanTab[Idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q <= d;
    end
  end

  assign a_o = q;

endmodule

/* rtl/awa_vec_cell.sv */
module awa_vec_cell import awa_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t a_i,
  output vec_t a_o
);

  vec_t d, q;
  logic signed [VecW-1:0] dx, dy;

  always_comb begin
    dx = a_i.y >>> Idx;
    dy = a_i.x >>> Idx;
    d  = a_i;
    if (a_i.y >= 0) begin
      d.x = a_i.x + dx;
      d.y = a_i.y - dy;
      d.z = a_i.z + AtanTab[Idx];
    end else begin
      d.x = a_i.x - dx;
      d.y = a_i.y + dy;
      d.z = a_i.z - AtanTab[Idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q <= d;
    end
  end

  assign a_o = q;

endmodule

/* rtl/ackermann_wheel_angles_top.sv */
// Ackermann wheel angles from a commanded centre steering angle.
// Input channel: in_valid_i / in_stall_o carry steer_command_i (signed Q2.13 rad).
// Output channel: out_valid_o / out_stall_i carry clamped_angle_o, left_angle_o
// and right_angle_o (signed Q1.13 rad), one result beat per input beat.
// Configuration: cfg_we_i writes cfg_data_i to track width (index 0) or wheel
// base (index 1), both unsigned Q8.8, reset to 1.0.
// From the accepting edge to the result beat a sample passes an input register,
// a rotation CORDIC row for sin/cos, a multiply stage for k*sin, a stage that
// forms both denominators, two vectoring CORDIC rows side by side and the
// output register.
// Throughput is one beat a cycle unless the output or the divider stalls it;
// every cell advances together. After each configuration write, k is rebuilt
// as track/(2*wheel base) by a bit-serial divider while the input stalls.
// Reset empties the pipeline and restores the register defaults; k is ready
// at once. While the receiver stalls a valid result, the whole row holds and
// the input stalls with it.
module ackermann_wheel_angles_top import awa_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [LenW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [InW-1:0]  steer_command_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] clamped_angle_o,
  output logic signed [OutW-1:0] left_angle_o,
  output logic signed [OutW-1:0] right_angle_o
);

  localparam int unsigned N       = CORDIC_STAGES;
  localparam int unsigned MetaLen = 2 * N + 3;

  logic [LenW-1:0] track_q, base_q;
  logic            upd_q, kbusy;
  logic [KW-1:0]   k;
  kdiv_ctl_t       kctl;

  logic en, accept;
  logic [MetaLen-1:0]     vld_q;
  logic signed [OutW-1:0] ang_q  [MetaLen];
  logic                   dead_q [MetaLen];

  logic signed [InW-1:0]  cmd_c;
  logic signed [OutW-1:0] ang_c;
  logic signed [RotW-1:0] a30, mag;

  rot_t rot_s [N+1];
  vec_t vl_s  [N+1];
  vec_t vr_s  [N+1];

  logic signed [VecW-1:0]        ks_q, s_q, c_q;
  logic signed [KW+RotW:0]       prod;
  logic signed [VecW-1:0]        dl, dr;
  vec_t                          vl_d, vr_d;

  logic                   out_valid_q;
  logic signed [OutW-1:0] clamped_q, left_q, right_q;
  logic signed [RotW-1:0] zl, zr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= LenReset;
      base_q  <= LenReset;
      upd_q   <= 1'b0;
    end else begin
      upd_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTrack: track_q <= cfg_data_i;
          CfgBase:  base_q  <= cfg_data_i;
          default:  track_q <= track_q;
        endcase
      end
    end
  end

  assign kctl.start = upd_q;
  assign kctl.busy  = upd_q;

  awa_kdiv u_kdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .track_i (track_q),
    .base_i  (base_q),
    .ctl_i   (kctl),
    .busy_o  (kbusy),
    .k_o     (k)
  );

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en || kbusy;
  assign accept     = in_valid_i && !in_stall_o;

  // clamp and deadband test
  always_comb begin
    cmd_c = steer_command_i;
    if (cmd_c > InW'(Lim)) begin
      ang_c = Lim;
    end else if (cmd_c < -InW'(Lim)) begin
      ang_c = -Lim;
    end else begin
      ang_c = cmd_c[OutW-1:0];
    end
    a30 = RotW'(ang_c) <<< Sh;
    mag = (a30 < 0) ? -a30 : a30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[MetaLen-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0]  <= ang_c;
      dead_q[0] <= (mag < DeadbandQ30);
      rot_s[0]  <= '{x: InvGainQ30, y: '0, z: a30};
      for (int i = 1; i < MetaLen; i++) begin
        ang_q[i]  <= ang_q[i-1];
        dead_q[i] <= dead_q[i-1];
      end
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_rot
    awa_rot_cell #(.Idx(j)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (rot_s[j]),
      .a_o   (rot_s[j+1])
    );
  end

  // k*sin, floor-shifted back to Q30
  assign prod = $signed({1'b0, k}) * rot_s[N].y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ks_q <= VecW'(prod >>> 16);
      s_q  <= VecW'(rot_s[N].y);
      c_q  <= VecW'(rot_s[N].x);
    end
  end

  // denominators, folded by pi where negative
  always_comb begin
    dl = c_q - ks_q;
    dr = c_q + ks_q;
    vl_d.spec    = (dl == '0);
    vl_d.spec_nz = (s_q != '0);
    vl_d.z       = '0;
    vl_d.x       = (dl < 0) ? -dl : dl;
    vl_d.y       = (dl < 0) ? -s_q : s_q;
    vr_d.spec    = (dr == '0);
    vr_d.spec_nz = (s_q != '0);
    vr_d.z       = '0;
    vr_d.x       = (dr < 0) ? -dr : dr;
    vr_d.y       = (dr < 0) ? -s_q : s_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vl_s[0] <= vl_d;
      vr_s[0] <= vr_d;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_vec
    awa_vec_cell #(.Idx(j)) u_left (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (vl_s[j]),
      .a_o   (vl_s[j+1])
    );
    awa_vec_cell #(.Idx(j)) u_right (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (vr_s[j]),
      .a_o   (vr_s[j+1])
    );
  end

  always_comb begin
    zl = vl_s[N].z;
    zr = vr_s[N].z;
    if (vl_s[N].spec) begin
      zl = vl_s[N].spec_nz ? PiHalfQ30 : '0;
    end
    if (vr_s[N].spec) begin
      zr = vr_s[N].spec_nz ? PiHalfQ30 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[MetaLen-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clamped_q <= ang_q[MetaLen-1];
      left_q    <= dead_q[MetaLen-1] ? '0 : fold_out(zl);
      right_q   <= dead_q[MetaLen-1] ? '0 : fold_out(zr);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign clamped_angle_o = clamped_q;
  assign left_angle_o    = left_q;
  assign right_angle_o   = right_q;

endmodule

/* rtl/awa_chk.sv */
module awa_chk import awa_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [OutW-1:0] clamped_angle_o,
  input logic signed [OutW-1:0] left_angle_o,
  input logic signed [OutW-1:0] right_angle_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_angle_o))
    else $error("stalled result beat changed");

  // a held result beat holds the input side too
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input beat taken while result stalled");

  a_clamp_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> clamped_angle_o <= Lim && clamped_angle_o >= -Lim)
    else $error("clamped angle out of range");

  a_wheel_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_angle_o <= Lim && left_angle_o >= -Lim &&
                    right_angle_o <= Lim && right_angle_o >= -Lim)
    else $error("wheel angle out of range");

  // zero command lies inside the deadband
  a_deadband: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_angle_o == '0 |-> left_angle_o == '0 && right_angle_o == '0)
    else $error("deadband not applied");

endmodule

bind ackermann_wheel_angles_top awa_chk u_awa_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .clamped_angle_o (clamped_angle_o),
  .left_angle_o    (left_angle_o),
  .right_angle_o   (right_angle_o)
);
